// File: hdl/mrrc_pkg.sv
// Shared types, codes and the CRC-16 byte update for the Modbus RTU response checker.
package mrrc_pkg;

   localparam int unsigned POS_W       = 7;
   localparam int unsigned IDX_OUT_W   = 3;
   localparam logic [7:0]  FUNC_READ   = 8'h03;
   localparam logic [15:0] CRC_INIT    = 16'hFFFF;
   localparam logic [15:0] CRC_POLY    = 16'hA001;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_CRC = 2'd1,
      STATUS_HDR = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [1:0]           status;
      logic [IDX_OUT_W-1:0] reg_index;
      logic [15:0]          reg_value;
      logic                 last;
   } rsp_type;

   // Modbus CRC-16, reflected, one byte folded in
   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                              input logic [7:0]  data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int i = 0; i < 8; i++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

// File: hdl/mrrc_front.sv
// Byte parser: CRC, header check, value assembly and frame-end classification.
module mrrc_front #(
   parameter int unsigned REG_COUNT = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mrrc_pkg::req_type      req_payload,
   input  logic                   csr_wr_en,
   input  logic [7:0]             csr_wr_data,
   input  logic                   drain_busy,
   output logic                   push,
   output mrrc_pkg::status_type   push_status,
   output logic                   wr_en,
   output logic [((REG_COUNT > 1) ? $clog2(REG_COUNT) : 1)-1:0] wr_addr,
   output logic [15:0]            wr_data
);
   import mrrc_pkg::*;

   localparam int unsigned IDX_W     = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam int unsigned FRAME_LEN = 5 + 2 * REG_COUNT;
   localparam logic [7:0]  BYTE_CNT  = 8'(2 * REG_COUNT);
   localparam logic [POS_W-1:0] POS_DATA = POS_W'(3);
   localparam logic [POS_W-1:0] POS_CRC  = POS_W'(3 + 2 * REG_COUNT);
   localparam logic [POS_W-1:0] POS_END  = POS_W'(FRAME_LEN - 1);

   logic             active_ff, active_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      crc_ff, crc_in;
   logic             hdr_ok_ff, hdr_ok_in;
   logic [7:0]       held_ff, held_in;
   logic [7:0]       dev_addr_ff, dev_addr_in;

   logic             accept;
   logic             act_eff;
   logic [POS_W-1:0] pos_cur;
   logic [15:0]      crc_base, crc_new;
   logic             hdr_base, hdr_new;
   logic [7:0]       held_base;
   logic [POS_W-1:0] off;
   logic [7:0]       rx;

   // payload bytes would overwrite values still being read out
   assign req_stall = drain_busy && active_ff && (pos_ff >= POS_DATA);
   assign accept    = req_valid && !req_stall;
   assign rx        = req_payload.rx_byte;

   always_comb begin
      act_eff   = req_payload.frame_start || active_ff;
      pos_cur   = req_payload.frame_start ? '0 : pos_ff;
      crc_base  = req_payload.frame_start ? CRC_INIT : crc_ff;
      hdr_base  = req_payload.frame_start ? 1'b1 : hdr_ok_ff;
      held_base = req_payload.frame_start ? 8'h00 : held_ff;
      crc_new   = crc16_byte(crc_base, rx);
      off       = pos_cur - POS_DATA;

      hdr_new = hdr_base;
      if (pos_cur == POS_W'(0)) begin
         if (rx != dev_addr_ff) hdr_new = 1'b0;
      end else if (pos_cur == POS_W'(1)) begin
         if (rx != FUNC_READ) hdr_new = 1'b0;
      end else if (pos_cur == POS_W'(2)) begin
         if (rx != BYTE_CNT) hdr_new = 1'b0;
      end

      active_in   = active_ff;
      pos_in      = pos_ff;
      crc_in      = crc_ff;
      hdr_ok_in   = hdr_ok_ff;
      held_in     = held_ff;
      dev_addr_in = csr_wr_en ? csr_wr_data : dev_addr_ff;
      push        = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = IDX_W'(off >> 1);
      wr_data     = {held_base, rx};

      if (crc_new != 16'h0000) begin
         push_status = STATUS_CRC;
      end else if (!hdr_new) begin
         push_status = STATUS_HDR;
      end else begin
         push_status = STATUS_OK;
      end

      if (accept && act_eff) begin
         crc_in    = crc_new;
         hdr_ok_in = hdr_new;
         held_in   = held_base;
         if (pos_cur >= POS_DATA && pos_cur < POS_CRC) begin
            if (!off[0]) begin
               held_in = rx;
            end else begin
               wr_en = 1'b1;
            end
         end
         if (pos_cur == POS_END) begin
            active_in = 1'b0;
            pos_in    = '0;
            push      = 1'b1;
         end else begin
            active_in = 1'b1;
            pos_in    = pos_cur + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         pos_ff      <= '0;
         crc_ff      <= CRC_INIT;
         hdr_ok_ff   <= 1'b1;
         held_ff     <= 8'h00;
         dev_addr_ff <= 8'h01;
      end else begin
         active_ff   <= active_in;
         pos_ff      <= pos_in;
         crc_ff      <= crc_in;
         hdr_ok_ff   <= hdr_ok_in;
         held_ff     <= held_in;
         dev_addr_ff <= dev_addr_in;
      end
   end

endmodule

// File: hdl/mrrc_fifo.sv
// Two-entry queue of frame verdicts between the parser and the result sequencer.
module mrrc_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mrrc_pkg::status_type push_data,
   input  logic                 pop,
   output logic                 not_empty,
   output logic                 full,
   output mrrc_pkg::status_type head
);
   import mrrc_pkg::*;

   status_type entry_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;

   assign not_empty = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign head      = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? ~wptr_ff : wptr_ff;
      rptr_in  = pop ? ~rptr_ff : rptr_ff;
      count_in = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!full || pop))
      else $error("verdict queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("verdict queue underflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != 2'd3))
      else $error("verdict queue count out of range");
`endif

endmodule

// File: hdl/mrrc_back.sv
// Result sequencer: value memory, readout of a good frame, output register.
module mrrc_back #(
   parameter int unsigned REG_COUNT = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [((REG_COUNT > 1) ? $clog2(REG_COUNT) : 1)-1:0] wr_addr,
   input  logic [15:0]          wr_data,
   input  logic                 q_not_empty,
   input  mrrc_pkg::status_type q_head,
   output logic                 q_pop,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mrrc_pkg::rsp_type    rsp_payload
);
   import mrrc_pkg::*;

   localparam int unsigned IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REG_COUNT - 1);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_FETCH = 3'b010,
      ST_SEND  = 3'b100
   } state_type;

   logic [15:0]      mem [REG_COUNT];
   logic [15:0]      rd_data_ff;
   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;
   logic             out_free;

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign busy        = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[idx_ff];
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      q_pop        = 1'b0;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_not_empty) begin
               if (q_head == STATUS_OK) begin
                  q_pop    = 1'b1;
                  idx_in   = '0;
                  state_in = ST_FETCH;
               end else if (out_free) begin
                  q_pop            = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_in.status    = q_head;
                  rsp_in.reg_index = '0;
                  rsp_in.reg_value = 16'h0000;
                  rsp_in.last      = 1'b1;
               end
            end
         end
         ST_FETCH: begin
            // read data for idx_ff lands in rd_data_ff this edge
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = STATUS_OK;
               rsp_in.reg_index = IDX_OUT_W'(idx_ff);
               rsp_in.reg_value = rd_data_ff;
               rsp_in.last      = (idx_ff == IDX_LAST);
               if (idx_ff == IDX_LAST) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_fetch_then_send: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |=> (state_ff == ST_SEND))
      else $error("fetch not followed by send");

   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK) |->
         (rsp_ff.last && rsp_ff.reg_index == '0 && rsp_ff.reg_value == 16'h0000))
      else $error("error result not a lone zero transfer");

   a_no_pop_mid_frame: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("verdict popped while a frame drains");
`endif

endmodule

// File: hdl/modbus_rtu_read_response_checker_core.sv
// Top level of the Modbus RTU read-holding-registers response checker.
// Accepts one received byte per transfer, flagged at each frame's first byte, runs the
// Modbus CRC-16 over the frame, checks address, function 0x03 and byte count, and on the
// frame's final byte gives one status transfer on error (CRC error ahead of header error)
// or REG_COUNT register transfers on a good frame, last set on the final one. A byte is
// taken every cycle, except that value and CRC bytes stall while the previous frame's
// results are still being read out. Readout of a good frame goes through the single-read-
// port value memory and the output register, a FETCH and a SEND state per register; an
// error frame's one transfer is loaded into the output register straight from idle.
// The expected slave address resets to 1 and is written through csr_wr_en/csr_wr_data.
module modbus_rtu_read_response_checker_core #(
   parameter int unsigned REG_COUNT = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mrrc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mrrc_pkg::rsp_type rsp_payload,
   input  logic              csr_wr_en,
   input  logic [7:0]        csr_wr_data
);
   import mrrc_pkg::*;

   localparam int unsigned IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

   logic             push, pop, q_not_empty, q_full, back_busy, drain_busy;
   status_type       push_status, q_head;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [15:0]      wr_data;

   assign drain_busy = q_not_empty || q_full || back_busy;

   mrrc_front #(.REG_COUNT(REG_COUNT)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .drain_busy  (drain_busy),
      .push        (push),
      .push_status (push_status),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data)
   );

   mrrc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_status),
      .pop       (pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (q_head)
   );

   mrrc_back #(.REG_COUNT(REG_COUNT)) u_back (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .q_not_empty (q_not_empty),
      .q_head      (q_head),
      .q_pop       (pop),
      .busy        (back_busy),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
